// ===== design/bpa_pkg.sv =====
package bpa_pkg;

  // payload field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PADDR_W  = 27;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FREE_W   = 16;
  localparam int unsigned TOTAL_W  = 20;

  // configuration register widths
  localparam int unsigned KB_W     = 22;
  localparam int unsigned KFIRST_W = 20;
  localparam int unsigned KLAST_W  = 21;

  // page geometry: 4 KiB pages, low memory ends at the 1 MB page
  localparam int unsigned PAGE_SHIFT    = 12;
  localparam int unsigned LOW_MEM_PAGE  = 256;
  localparam int unsigned LOW_MEM_KB    = 1024;
  localparam int unsigned WORD_BITS     = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [FREE_W-1:0]  FREE_MAX  = '1;

  // commands
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OOM     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_DBLFREE = 2'd3;

  // configuration register indexes (byte address bits [3:2])
  localparam int unsigned APB_ADDR_W = 4;
  localparam logic [1:0] REG_MEM_UPPER = 2'd0;
  localparam logic [1:0] REG_KFIRST    = 2'd1;
  localparam logic [1:0] REG_KLAST     = 2'd2;

  // configuration reset values
  localparam logic [KB_W-1:0]     MEM_UPPER_RST = 22'd31744;
  localparam logic [KFIRST_W-1:0] KFIRST_RST    = 20'd256;
  localparam logic [KLAST_W-1:0]  KLAST_RST     = 21'd288;

endpackage

// ===== design/bpa_cmd_if.sv =====
interface bpa_cmd_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

// ===== design/bpa_res_if.sv =====
interface bpa_res_if import bpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PADDR_W-1:0]  page_address;
  logic [STATUS_W-1:0] status;
  logic [FREE_W-1:0]   free_count;
  logic [TOTAL_W-1:0]  total_count;

  modport source (output valid, output page_address, output status, output free_count,
                  output total_count, input ready);
  modport sink   (input valid, input page_address, input status, input free_count,
                  input total_count, output ready);
endinterface

// ===== design/bitmap_page_allocator_unit.sv =====
// First-fit physical page allocator over a bitmap of MAP_WORDS 32-bit words held in one
// single-port-write, registered-read memory (1 = page used). One request is worked at a
// time; the result waits in an output register so the next request can be taken at once.
// Init writes one bitmap word per cycle; alloc reads one word per cycle in order until
// the first word with a free bit, or through the last word when memory is exhausted;
// free reads the page's word, then clears its bit unless already clear; an out-of-range
// free or an unknown command goes straight to the result. After reset the bitmap is
// filled with ones by a clearing pass during which no request is taken; configuration
// writes are accepted throughout. Configuration registers sit at byte addresses 0, 4, 8.
module bitmap_page_allocator_unit
  import bpa_pkg::*;
#(
  parameter int unsigned MAP_WORDS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bpa_cmd_if.sink               cmd_i,
  bpa_res_if.source             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned AW        = $clog2(MAP_WORDS);
  localparam int unsigned MAP_PAGES = MAP_WORDS * WORD_BITS;
  localparam int unsigned PW        = AW + 5;
  localparam int unsigned CW        = $clog2(MAP_PAGES + 1);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_INIT_CALC = 4'd2;
  localparam logic [3:0] S_INIT_CNT  = 4'd3;
  localparam logic [3:0] S_INIT_OV   = 4'd4;
  localparam logic [3:0] S_INIT_FILL = 4'd5;
  localparam logic [3:0] S_ALLOC     = 4'd6;
  localparam logic [3:0] S_FREE_RD   = 4'd7;
  localparam logic [3:0] S_FREE_CHK  = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  // configuration registers
  logic [KB_W-1:0]     cfg_upper_q;
  logic [KFIRST_W-1:0] cfg_kfirst_q;
  logic [KLAST_W-1:0]  cfg_klast_q;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_upper_q  <= MEM_UPPER_RST;
      cfg_kfirst_q <= KFIRST_RST;
      cfg_klast_q  <= KLAST_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_MEM_UPPER: cfg_upper_q  <= pwdata[KB_W-1:0];
        REG_KFIRST:    cfg_kfirst_q <= pwdata[KFIRST_W-1:0];
        REG_KLAST:     cfg_klast_q  <= pwdata[KLAST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MEM_UPPER: prdata = 32'(cfg_upper_q);
      REG_KFIRST:    prdata = 32'(cfg_kfirst_q);
      REG_KLAST:     prdata = 32'(cfg_klast_q);
      default:       prdata = '0;
    endcase
  end

  // bitmap memory
  logic [31:0]   map_mem [MAP_WORDS];
  logic [31:0]   rdata_q;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[waddr] <= wdata;
    end
    rdata_q <= map_mem[raddr];
  end

  // control and working state
  logic [3:0]          state_q, state_d;
  logic [AW-1:0]       wcnt_q, wcnt_d;
  logic [AW-1:0]       scan_q, scan_d;
  logic [AW-1:0]       dw_q, dw_d;
  logic                rvld_q, rvld_d;
  logic                issued_q, issued_d;
  logic [PW-1:0]       fpage_q, fpage_d;
  logic [CW-1:0]       free_q, free_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic [CW-1:0]       lim_q, lim_d;
  logic [PW-1:0]       kf_q, kf_d;
  logic [PW-1:0]       klast_q, klast_d;
  logic                kv_q, kv_d;
  logic [CW-1:0]       base_q, base_d;
  logic [PW-1:0]       lo_q, lo_d;
  logic [PW-1:0]       hi_q, hi_d;
  logic                ovv_q, ovv_d;
  logic [PADDR_W-1:0]  rpage_q, rpage_d;
  logic [STATUS_W-1:0] rstat_q, rstat_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [PADDR_W-1:0]  out_page_q, out_page_d;
  logic [STATUS_W-1:0] out_stat_q, out_stat_d;
  logic [FREE_W-1:0]   out_free_q, out_free_d;
  logic [TOTAL_W-1:0]  out_total_q, out_total_d;

  assign cmd_i.ready        = (state_q == S_IDLE);
  assign res_o.valid        = out_valid_q;
  assign res_o.page_address = out_page_q;
  assign res_o.status       = out_stat_q;
  assign res_o.free_count   = out_free_q;
  assign res_o.total_count  = out_total_q;

  // init word for the current sweep position: a bit is clear when its page lies in
  // [1 MB page, limit) and outside the kernel range
  logic [31:0] init_word;
  always_comb begin
    logic [PW-1:0] p;
    for (int unsigned b = 0; b < WORD_BITS; b++) begin
      p = {wcnt_q, 5'(b)};
      init_word[b] = !((CW'(p) >= CW'(LOW_MEM_PAGE)) && (CW'(p) < lim_q) &&
                       !(kv_q && (p >= kf_q) && (p <= klast_q)));
    end
  end

  // lowest clear bit of the scanned word
  logic [31:0] lowest_oh;
  logic [4:0]  lowest_idx;
  always_comb begin
    lowest_oh  = ~rdata_q & (rdata_q + 32'd1);
    lowest_idx = '0;
    for (int unsigned b = 0; b < WORD_BITS; b++) begin
      if (lowest_oh[b]) begin
        lowest_idx = lowest_idx | 5'(b);
      end
    end
  end

  // main sequencer
  always_comb begin
    logic [22:0]         kb_sum;
    logic [20:0]         tot_raw;
    logic [TOTAL_W-1:0]  tot_sat;
    logic                lim_gt;
    logic [PW-1:0]       hi_cand;
    logic [PW-1:0]       lo_cand;
    logic [31:0]         pa32;
    logic [TOTAL_W-1:0]  cmd_page;
    logic                out_free;

    state_d     = state_q;
    wcnt_d      = wcnt_q;
    scan_d      = scan_q;
    dw_d        = dw_q;
    rvld_d      = rvld_q;
    issued_d    = issued_q;
    fpage_d     = fpage_q;
    free_d      = free_q;
    total_d     = total_q;
    lim_d       = lim_q;
    kf_d        = kf_q;
    klast_d     = klast_q;
    kv_d        = kv_q;
    base_d      = base_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    ovv_d       = ovv_q;
    rpage_d     = rpage_q;
    rstat_d     = rstat_q;
    out_valid_d = out_valid_q;
    out_page_d  = out_page_q;
    out_stat_d  = out_stat_q;
    out_free_d  = out_free_q;
    out_total_d = out_total_q;

    mem_we = 1'b0;
    waddr  = wcnt_q;
    wdata  = '1;
    raddr  = scan_q;

    kb_sum   = 23'(LOW_MEM_KB) + {1'b0, cfg_upper_q};
    tot_raw  = kb_sum[22:2];
    tot_sat  = (tot_raw > 21'(TOTAL_MAX)) ? TOTAL_MAX : tot_raw[TOTAL_W-1:0];
    lim_gt   = lim_q > CW'(LOW_MEM_PAGE);
    lo_cand  = (kf_q > PW'(LOW_MEM_PAGE)) ? kf_q : PW'(LOW_MEM_PAGE);
    hi_cand  = (CW'(klast_q) < (lim_q - CW'(1))) ? klast_q : PW'(lim_q - CW'(1));
    pa32     = 32'({dw_q, lowest_idx}) << PAGE_SHIFT;
    cmd_page = cmd_i.address[ADDR_W-1:PAGE_SHIFT];
    out_free = !out_valid_q || res_o.ready;

    // drain the output register
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // fill the bitmap with ones after reset
      S_CLEAR: begin
        mem_we = 1'b1;
        waddr  = wcnt_q;
        wdata  = '1;
        wcnt_d = wcnt_q + AW'(1);
        if (wcnt_q == AW'(MAP_WORDS - 1)) begin
          wcnt_d  = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_i.valid) begin
          rpage_d = '0;
          rstat_d = STAT_OK;
          case (cmd_i.command)
            CMD_INIT: state_d = S_INIT_CALC;
            CMD_ALLOC: begin
              scan_d   = '0;
              rvld_d   = 1'b0;
              issued_d = 1'b0;
              state_d  = S_ALLOC;
            end
            CMD_FREE: begin
              if (32'(cmd_page) >= 32'(MAP_PAGES)) begin
                rstat_d = STAT_RANGE;
                state_d = S_DONE;
              end else begin
                fpage_d = cmd_page[PW-1:0];
                state_d = S_FREE_RD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // total pages, free limit and clamped kernel range
      S_INIT_CALC: begin
        total_d = tot_sat;
        lim_d   = (32'(tot_sat) < 32'(MAP_PAGES)) ? CW'(tot_sat) : CW'(MAP_PAGES);
        kf_d    = cfg_kfirst_q[PW-1:0];
        kv_d    = (32'(cfg_kfirst_q) < 32'(MAP_PAGES)) &&
                  ({1'b0, cfg_kfirst_q} <= cfg_klast_q);
        klast_d = (32'(cfg_klast_q) < 32'(MAP_PAGES)) ? cfg_klast_q[PW-1:0]
                                                       : PW'(MAP_PAGES - 1);
        state_d = S_INIT_CNT;
      end

      // free span and its overlap with the kernel range
      S_INIT_CNT: begin
        base_d  = lim_gt ? (lim_q - CW'(LOW_MEM_PAGE)) : '0;
        lo_d    = lo_cand;
        hi_d    = hi_cand;
        ovv_d   = kv_q && lim_gt && (hi_cand >= lo_cand);
        state_d = S_INIT_OV;
      end

      S_INIT_OV: begin
        free_d  = ovv_q ? (base_q - CW'(hi_q - lo_q) - CW'(1)) : base_q;
        wcnt_d  = '0;
        state_d = S_INIT_FILL;
      end

      // rewrite every bitmap word
      S_INIT_FILL: begin
        mem_we = 1'b1;
        waddr  = wcnt_q;
        wdata  = init_word;
        wcnt_d = wcnt_q + AW'(1);
        if (wcnt_q == AW'(MAP_WORDS - 1)) begin
          wcnt_d  = '0;
          state_d = S_DONE;
        end
      end

      // scan words in order, one read per cycle, check the previous read
      S_ALLOC: begin
        raddr    = scan_q;
        rvld_d   = !issued_q;
        dw_d     = scan_q;
        scan_d   = scan_q + AW'(1);
        issued_d = issued_q || (scan_q == AW'(MAP_WORDS - 1));
        if (rvld_q) begin
          if (rdata_q != '1) begin
            mem_we  = 1'b1;
            waddr   = dw_q;
            wdata   = rdata_q | lowest_oh;
            free_d  = free_q - CW'(1);
            rpage_d = pa32[PADDR_W-1:0];
            state_d = S_DONE;
          end else if (dw_q == AW'(MAP_WORDS - 1)) begin
            rstat_d = STAT_OOM;
            state_d = S_DONE;
          end
        end
      end

      S_FREE_RD: begin
        raddr   = fpage_q[PW-1:5];
        state_d = S_FREE_CHK;
      end

      S_FREE_CHK: begin
        if (!rdata_q[fpage_q[4:0]]) begin
          rstat_d = STAT_DBLFREE;
        end else begin
          mem_we = 1'b1;
          waddr  = fpage_q[PW-1:5];
          wdata  = rdata_q & ~(32'd1 << fpage_q[4:0]);
          free_d = free_q + CW'(1);
        end
        state_d = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_page_d  = rpage_q;
          out_stat_d  = rstat_q;
          out_free_d  = (32'(free_q) > 32'(FREE_MAX)) ? FREE_MAX : FREE_W'(free_q);
          out_total_d = total_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      wcnt_q      <= '0;
      rvld_q      <= 1'b0;
      issued_q    <= 1'b0;
      free_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wcnt_q      <= wcnt_d;
      rvld_q      <= rvld_d;
      issued_q    <= issued_d;
      free_q      <= free_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    dw_q        <= dw_d;
    fpage_q     <= fpage_d;
    lim_q       <= lim_d;
    kf_q        <= kf_d;
    klast_q     <= klast_d;
    kv_q        <= kv_d;
    base_q      <= base_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    ovv_q       <= ovv_d;
    rpage_q     <= rpage_d;
    rstat_q     <= rstat_d;
    out_page_q  <= out_page_d;
    out_stat_q  <= out_stat_d;
    out_free_q  <= out_free_d;
    out_total_q <= out_total_d;
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import bpa_pkg::*;

  localparam int unsigned MAP_WORDS = 1024;
  localparam int unsigned MAP_PAGES = MAP_WORDS * WORD_BITS;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int unsigned SETTLE_CYCLES = MAP_WORDS + 80;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_REQUESTS = 75;

  typedef struct packed {
    logic [PADDR_W-1:0]  page_address;
    logic [STATUS_W-1:0] status;
    logic [FREE_W-1:0]   free_count;
    logic [TOTAL_W-1:0]  total_count;
  } page_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  bpa_cmd_if cmd_if ();
  bpa_res_if res_if ();

  bitmap_page_allocator_unit #(
    .MAP_WORDS(MAP_WORDS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // allocator mirror: bitmap, counters and configuration
  logic [31:0]         page_bits [MAP_WORDS];
  int unsigned         pages_free;
  int unsigned         pages_total;
  logic [KB_W-1:0]     cfg_mem_kb;
  logic [KFIRST_W-1:0] cfg_kern_first;
  logic [KLAST_W-1:0]  cfg_kern_last;
  int unsigned         held_pages [$];

  page_result_t    page_results_due [$];
  int unsigned     mismatches;
  bit              idle_on;
  int unsigned     res_hold;
  longint unsigned cycle_count;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) begin
      $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    end
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return $urandom_range(1, 3);
    end
    if (r < 92) begin
      return $urandom_range(4, 9);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic bit page_in_use(int unsigned pg);
    return page_bits[pg / WORD_BITS][pg % WORD_BITS];
  endfunction

  function automatic void set_page(int unsigned pg, bit used);
    page_bits[pg / WORD_BITS][pg % WORD_BITS] = used;
  endfunction

  function automatic void reset_mirror();
    foreach (page_bits[w]) page_bits[w] = '1;
    pages_free     = 0;
    pages_total    = 0;
    cfg_mem_kb     = MEM_UPPER_RST;
    cfg_kern_first = KFIRST_RST;
    cfg_kern_last  = KLAST_RST;
    held_pages.delete();
  endfunction

  // init: free from the 1 MB page to the end of memory, then re-mark the kernel
  function automatic void rebuild_map();
    longint unsigned total;
    int unsigned     lim;
    int unsigned     last;
    int unsigned     p;
    total = (64'(LOW_MEM_KB) + 64'(cfg_mem_kb)) << 10;
    total = total >> PAGE_SHIFT;
    if (total > 64'(TOTAL_MAX)) begin
      total = 64'(TOTAL_MAX);
    end
    pages_total = int'(total);
    foreach (page_bits[w]) page_bits[w] = '1;
    pages_free = 0;
    lim = (pages_total < MAP_PAGES) ? pages_total : MAP_PAGES;
    for (p = LOW_MEM_PAGE; p < lim; p++) begin
      set_page(p, 1'b0);
      pages_free++;
    end
    if (cfg_kern_first < MAP_PAGES && cfg_kern_first <= cfg_kern_last) begin
      last = (cfg_kern_last < MAP_PAGES) ? int'(cfg_kern_last) : MAP_PAGES - 1;
      for (p = cfg_kern_first; p <= last; p++) begin
        if (!page_in_use(p)) begin
          set_page(p, 1'b1);
          pages_free--;
        end
      end
    end
    held_pages.delete();
  endfunction

  function automatic page_result_t predict_page_result(logic [CMD_W-1:0] cmd,
                                                       logic [ADDR_W-1:0] addr);
    page_result_t res;
    int unsigned  w;
    int unsigned  b;
    int unsigned  pg;
    bit           found;
    res = '0;
    res.status = STAT_OK;
    case (cmd)
      CMD_INIT: begin
        rebuild_map();
      end
      CMD_ALLOC: begin
        // first fit: skip full words, take the lowest clear bit
        found = 1'b0;
        for (w = 0; w < MAP_WORDS && !found; w++) begin
          if (page_bits[w] != '1) begin
            for (b = 0; b < WORD_BITS && !found; b++) begin
              if (!page_bits[w][b]) begin
                pg = w * WORD_BITS + b;
                set_page(pg, 1'b1);
                pages_free--;
                found = 1'b1;
                res.page_address = PADDR_W'(pg << PAGE_SHIFT);
                held_pages.push_back(pg);
              end
            end
          end
        end
        if (!found) begin
          res.status = STAT_OOM;
        end
      end
      CMD_FREE: begin
        pg = addr >> PAGE_SHIFT;
        if (pg >= MAP_PAGES) begin
          res.status = STAT_RANGE;
        end else if (!page_in_use(pg)) begin
          res.status = STAT_DBLFREE;
        end else begin
          set_page(pg, 1'b0);
          pages_free++;
        end
      end
      default: ;
    endcase
    res.free_count  = (pages_free > FREE_MAX) ? FREE_MAX : FREE_W'(pages_free);
    res.total_count = TOTAL_W'(pages_total);
    return res;
  endfunction

  // request driver: optional gap, then hold valid until accepted
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      cmd_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= cmd;
    cmd_if.address <= addr;
    do @(posedge clk_i); while (!cmd_if.ready);
    page_results_due.push_back(predict_page_result(cmd, addr));
  endtask

  // drop valid and wait until every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (page_results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(logic [1:0] idx, logic [31:0] want);
    logic [31:0] data;
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (data !== want) begin
      note_mismatch($sformatf("register %0d read: expected %h, got %h", idx, want, data));
    end
  endtask

  // write all three registers, mirror them masked to width, read them back
  task automatic write_config(logic [31:0] kb, logic [31:0] kfirst, logic [31:0] klast);
    apb_write(REG_MEM_UPPER, kb);
    apb_write(REG_KFIRST, kfirst);
    apb_write(REG_KLAST, klast);
    cfg_mem_kb     = kb[KB_W-1:0];
    cfg_kern_first = kfirst[KFIRST_W-1:0];
    cfg_kern_last  = klast[KLAST_W-1:0];
    check_register(REG_MEM_UPPER, 32'(cfg_mem_kb));
    check_register(REG_KFIRST, 32'(cfg_kern_first));
    check_register(REG_KLAST, 32'(cfg_kern_last));
  endtask

  // result checker
  initial begin
    page_result_t got;
    page_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.page_address = res_if.page_address;
        got.status       = res_if.status;
        got.free_count   = res_if.free_count;
        got.total_count  = res_if.total_count;
        if (page_results_due.size() == 0) begin
          note_mismatch($sformatf("result with no request pending: addr %h status %0d",
                                  got.page_address, got.status));
        end else begin
          want = page_results_due.pop_front();
          if (got.page_address !== want.page_address || got.status !== want.status ||
              got.free_count !== want.free_count || got.total_count !== want.total_count) begin
            note_mismatch($sformatf(
              "expected addr %h status %0d free %0d total %0d, got addr %h status %0d free %0d total %0d",
              want.page_address, want.status, want.free_count, want.total_count,
              got.page_address, got.status, got.free_count, got.total_count));
          end
        end
      end
    end
  end

  // result ready: long hold-off on demand, else random stalls
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (res_hold != 0) begin
        res_if.ready <= 1'b0;
        res_hold--;
      end else if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) begin
          stall_left = gap_len();
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // requests before any init: map is all used, counts are zero
  task automatic test_before_init();
    idle_on = 1'b0;
    send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, 32'h0030_0000);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_NONE, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // default layout: page zero, double free, out-of-range addresses, kernel pages
  task automatic test_default_layout();
    idle_on = 1'b1;
    send_request(CMD_INIT, '0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF);
    send_request(CMD_FREE, 32'h0000_0000);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, 32'h0000_0FFF);
    send_request(CMD_FREE, 32'h0000_0FFF);
    send_request(CMD_FREE, 32'hFFFF_FFFF);
    send_request(CMD_FREE, 32'h0800_0000);
    send_request(CMD_FREE, 32'h07FF_FFFF);
    send_request(CMD_FREE, 32'h07FF_F000);
    send_request(CMD_FREE, 32'h0010_0000);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_NONE, 32'h5555_AAAA);
    wait_drained();
  endtask

  // register extremes: no memory, saturated total, kernel past the map, empty range
  task automatic test_config_extremes();
    write_config(32'd0, 32'd0, 32'd0);
    send_request(CMD_INIT, '0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, 32'h0000_0000);
    wait_drained();
    write_config('1, '1, '1);
    send_request(CMD_INIT, '0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, 32'h07FF_F000);
    wait_drained();
    write_config(32'd4193279, 32'd300, 32'd1048576);
    send_request(CMD_INIT, '0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_FREE, 32'h0012_C000);
    send_request(CMD_ALLOC, '0);
    wait_drained();
    write_config(32'd1024, 32'd400, 32'd399);
    send_request(CMD_INIT, '0);
    send_request(CMD_ALLOC, '0);
    wait_drained();
    write_config(32'd2048, 32'd0, 32'd300);
    send_request(CMD_INIT, '0);
    send_request(CMD_ALLOC, '0);
    wait_drained();
  endtask

  // fill a tiny memory to out-of-memory, release it in random order, allocate again
  task automatic test_exhaust();
    int unsigned to_free [$];
    int unsigned i;
    write_config(32'd128, 32'd1, 32'd0);
    idle_on = 1'b1;
    send_request(CMD_INIT, '0);
    repeat (33) send_request(CMD_ALLOC, $urandom());
    to_free = held_pages;
    while (to_free.size() != 0) begin
      i = $urandom_range(0, to_free.size() - 1);
      send_request(CMD_FREE, (to_free[i] << PAGE_SHIFT) | $urandom_range(0, 4095));
      to_free.delete(i);
    end
    repeat (2) send_request(CMD_ALLOC, '0);
    wait_drained();
  endtask

  // receiver holds off while allocs keep coming, then sender waits for all
  task automatic test_backpressure();
    int unsigned i;
    write_config(32'(MEM_UPPER_RST), 32'(KFIRST_RST), 32'(KLAST_RST));
    idle_on = 1'b0;
    send_request(CMD_INIT, '0);
    wait_drained();
    res_hold = 300;
    repeat (12) send_request(CMD_ALLOC, '0);
    wait_drained();
    repeat (4) begin
      i = $urandom_range(0, held_pages.size() - 1);
      send_request(CMD_FREE, held_pages[i] << PAGE_SHIFT);
      held_pages.delete(i);
    end
    wait_drained();
  endtask

  task automatic random_config();
    logic [31:0] kb;
    logic [31:0] kf;
    logic [31:0] kl;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      kb = $urandom_range(0, 256);
    end else if (r < 8) begin
      kb = $urandom_range(0, 4096);
    end else begin
      kb = $urandom();
    end
    r = $urandom_range(0, 9);
    kf = (r < 7) ? $urandom_range(200, 400) : $urandom();
    r = $urandom_range(0, 9);
    if (r < 6) begin
      kl = 32'(kf[KFIRST_W-1:0]) + $urandom_range(0, 48);
    end else if (r < 8) begin
      kl = $urandom_range(0, kf[KFIRST_W-1:0]);
    end else begin
      kl = $urandom();
    end
    write_config(kb, kf, kl);
  endtask

  // mostly alloc and free of held pages, plus stray and out-of-range frees
  task automatic random_request();
    int unsigned r;
    int unsigned i;
    int unsigned pg;
    int unsigned lim;
    r   = $urandom_range(0, 99);
    lim = (pages_total < MAP_PAGES) ? pages_total : MAP_PAGES;
    if (r < 40 || (r < 70 && held_pages.size() == 0)) begin
      send_request(CMD_ALLOC, $urandom());
    end else if (r < 70) begin
      i  = $urandom_range(0, held_pages.size() - 1);
      pg = held_pages[i];
      held_pages.delete(i);
      send_request(CMD_FREE, (pg << PAGE_SHIFT) | $urandom_range(0, 4095));
    end else if (r < 82) begin
      pg = $urandom_range(0, lim);
      send_request(CMD_FREE, (pg << PAGE_SHIFT) | $urandom_range(0, 4095));
    end else if (r < 90) begin
      send_request(CMD_FREE, $urandom());
    end else if (r < 95) begin
      pg = MAP_PAGES - 2 + $urandom_range(0, 3);
      send_request(CMD_FREE, (pg << PAGE_SHIFT) | $urandom_range(0, 4095));
    end else if (r < 98) begin
      send_request(CMD_NONE, $urandom());
    end else begin
      send_request(CMD_INIT, $urandom());
    end
  endtask

  task automatic test_random();
    int unsigned phase;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_config();
      // one phase runs with no idling on either side
      idle_on = (phase != 2);
      send_request(CMD_INIT, $urandom());
      repeat (PHASE_REQUESTS) random_request();
      wait_drained();
    end
  endtask

  // main sequence
  initial begin
    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_INIT;
    cmd_if.address = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    idle_on        = 1'b0;
    res_hold       = 0;
    mismatches     = 0;
    reset_mirror();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_before_init();
    test_default_layout();
    test_config_extremes();
    test_exhaust();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && page_results_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
